// ===== hdl/opdg_pkg.sv =====
package opdg_pkg;

  // Default position width and fixed field widths
  localparam int unsigned POS_BITS_DEF = 24;
  localparam int unsigned GOAL_W       = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned STEP_W       = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_DISTANCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ACTIVE   = 1'd1;

  // Microprogram addresses
  localparam logic [STEP_W-1:0] STEP_WAIT       = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SQ_X       = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SQ_Y       = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SQ_Z       = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SUM        = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SQRT_INIT  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SQRT       = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT_FIRST = 4'd8;

  // Datapath operation of one step
  typedef enum logic [3:0] {
    UOP_WAIT_IN,
    UOP_SQ_X,
    UOP_SQ_Y,
    UOP_SQ_Z,
    UOP_SUM,
    UOP_SQRT_INIT,
    UOP_SQRT_STEP,
    UOP_EMIT_STEP,
    UOP_EMIT_FIRST
  } uop_t;

  // Stay on the current step while this condition holds
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_IN,
    HOLD_SQRT,
    HOLD_OUT_FULL
  } hold_t;

  // Where to go once the step is done
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_IF_NEW
  } jump_t;

  typedef struct packed {
    uop_t              uop;
    hold_t             hold;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic have_position;
    logic sqrt_last;
    logic out_busy;
  } stat_t;

  function automatic ucode_t make_uc(uop_t u, hold_t h, jump_t j, logic [STEP_W-1:0] t);
    ucode_t w;
    w.uop    = u;
    w.hold   = h;
    w.jump   = j;
    w.target = t;
    return w;
  endfunction

  // Control store
  function automatic ucode_t ucode_rom(logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      STEP_WAIT:       w = make_uc(UOP_WAIT_IN, HOLD_NO_IN, JMP_IF_NEW, STEP_EMIT_FIRST);
      STEP_SQ_X:       w = make_uc(UOP_SQ_X, HOLD_NONE, JMP_NEXT, STEP_WAIT);
      STEP_SQ_Y:       w = make_uc(UOP_SQ_Y, HOLD_NONE, JMP_NEXT, STEP_WAIT);
      STEP_SQ_Z:       w = make_uc(UOP_SQ_Z, HOLD_NONE, JMP_NEXT, STEP_WAIT);
      STEP_SUM:        w = make_uc(UOP_SUM, HOLD_NONE, JMP_NEXT, STEP_WAIT);
      STEP_SQRT_INIT:  w = make_uc(UOP_SQRT_INIT, HOLD_NONE, JMP_NEXT, STEP_WAIT);
      STEP_SQRT:       w = make_uc(UOP_SQRT_STEP, HOLD_SQRT, JMP_NEXT, STEP_WAIT);
      STEP_EMIT:       w = make_uc(UOP_EMIT_STEP, HOLD_OUT_FULL, JMP_ALWAYS, STEP_WAIT);
      STEP_EMIT_FIRST: w = make_uc(UOP_EMIT_FIRST, HOLD_OUT_FULL, JMP_ALWAYS, STEP_WAIT);
      default:         w = make_uc(UOP_WAIT_IN, HOLD_NONE, JMP_ALWAYS, STEP_WAIT);
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/opdg_if.sv =====
// Position sample channel
interface opdg_in_if #(
  parameter int unsigned POS_BITS = opdg_pkg::POS_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic signed [POS_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// Result channel
interface opdg_out_if;
  logic        valid;
  logic        ready;
  logic        first_sample;
  logic        feedback_valid;
  logic [31:0] traveled;
  logic        goal_reached;

  modport source (output valid, first_sample, feedback_valid, traveled, goal_reached,
                  input ready);
  modport sink   (input valid, first_sample, feedback_valid, traveled, goal_reached,
                  output ready);
endinterface

// ===== hdl/opdg_useq.sv =====
module opdg_useq (
  input  logic           clk,
  input  logic           rst,
  input  opdg_pkg::stat_t stat,
  output opdg_pkg::uop_t  uop
);
  import opdg_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uc;
  logic              hold;
  logic              take_jump;

  assign uc  = ucode_rom(step);
  assign uop = uc.uop;

  // Hold condition
  always_comb begin
    case (uc.hold)
      HOLD_NONE:     hold = 1'b0;
      HOLD_NO_IN:    hold = ~stat.in_valid;
      HOLD_SQRT:     hold = ~stat.sqrt_last;
      HOLD_OUT_FULL: hold = stat.out_busy;
      default:       hold = 1'b0;
    endcase
  end

  // Branch condition
  always_comb begin
    case (uc.jump)
      JMP_NEXT:   take_jump = 1'b0;
      JMP_ALWAYS: take_jump = 1'b1;
      JMP_IF_NEW: take_jump = ~stat.have_position;
      default:    take_jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (take_jump) begin
      step_next = uc.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/opdg_dpath.sv =====
module opdg_dpath #(
  parameter int unsigned POS_BITS = opdg_pkg::POS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  opdg_pkg::uop_t                     uop,
  output opdg_pkg::stat_t                    stat,
  input  logic                               cfg_we,
  input  logic [opdg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [opdg_pkg::CFG_DATA_W-1:0]    cfg_data,
  opdg_in_if.sink                            sample,
  opdg_out_if.source                         result
);
  import opdg_pkg::*;

  localparam int unsigned MAG_W  = POS_BITS;
  localparam int unsigned SQ_W   = 2 * POS_BITS;
  localparam int unsigned ACC_W  = 2 * POS_BITS + 2;
  localparam int unsigned ROOT_W = POS_BITS + 1;

  // Configuration
  logic [GOAL_W-1:0] goal_distance;
  logic              goal_active;

  // Position state
  logic signed [POS_BITS-1:0] cur_x, cur_y, cur_z;
  logic signed [POS_BITS-1:0] last_x, last_y, last_z;
  logic                       have_position;
  logic [GOAL_W-1:0]          path_total;

  // Arithmetic registers
  logic [SQ_W-1:0]  prod;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] root;
  logic [ACC_W-1:0] sq_bit;

  // Output register
  logic              out_valid;
  logic              out_first;
  logic              out_fb;
  logic [GOAL_W-1:0] out_traveled;
  logic              out_reached;

  logic                       accept;
  logic                       out_busy;
  logic                       emit_ok;
  logic signed [POS_BITS-1:0] op_a, op_b;
  logic [POS_BITS:0]          diff;
  logic [POS_BITS:0]          diff_abs;
  logic [MAG_W-1:0]           mag;
  logic [SQ_W-1:0]            sq;
  logic [ACC_W-1:0]           trial;
  logic                       trial_ge;
  logic [GOAL_W:0]            sum_ext;
  logic [GOAL_W-1:0]          total_sat;
  logic                       reached;

  assign sample.ready = (uop == UOP_WAIT_IN);
  assign accept       = sample.valid & sample.ready;
  assign out_busy     = out_valid & ~result.ready;
  assign emit_ok      = ~out_busy;

  assign stat.in_valid      = sample.valid;
  assign stat.have_position = have_position;
  assign stat.sqrt_last     = sq_bit[0];
  assign stat.out_busy      = out_busy;

  // Axis select for the squaring step
  always_comb begin
    case (uop)
      UOP_SQ_Y: begin
        op_a = cur_y;
        op_b = last_y;
      end
      UOP_SQ_Z: begin
        op_a = cur_z;
        op_b = last_z;
      end
      default: begin
        op_a = cur_x;
        op_b = last_x;
      end
    endcase
  end

  // |a - b| fits in POS_BITS bits
  assign diff     = {op_a[POS_BITS-1], op_a} - {op_b[POS_BITS-1], op_b};
  assign diff_abs = diff[POS_BITS] ? (~diff + (POS_BITS + 1)'(1)) : diff;
  assign mag      = diff_abs[MAG_W-1:0];
  assign sq       = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

  // One restoring square-root digit
  assign trial    = root + sq_bit;
  assign trial_ge = (rem >= trial);

  // Saturating path update and goal compare
  assign sum_ext   = {1'b0, path_total} + (GOAL_W + 1)'(root[ROOT_W-1:0]);
  assign total_sat = sum_ext[GOAL_W] ? {GOAL_W{1'b1}} : sum_ext[GOAL_W-1:0];
  assign reached   = (total_sat >= goal_distance);

  // Config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_distance <= {GOAL_W{1'b1}};
      goal_active   <= 1'b0;
      have_position <= 1'b0;
      path_total    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GOAL_DISTANCE) begin
          goal_distance <= cfg_data[GOAL_W-1:0];
        end
        if (cfg_index == REG_GOAL_ACTIVE) begin
          goal_active <= cfg_data[0];
        end
      end
      if (emit_ok && (uop == UOP_EMIT_FIRST)) begin
        have_position <= 1'b1;
      end
      if (emit_ok && (uop == UOP_EMIT_STEP)) begin
        path_total <= reached ? '0 : total_sat;
      end
      // Result valid: load on emit, drop once the beat is taken
      if (emit_ok && ((uop == UOP_EMIT_FIRST) || (uop == UOP_EMIT_STEP))) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x <= sample.pos_x;
      cur_y <= sample.pos_y;
      cur_z <= sample.pos_z;
    end
    case (uop)
      UOP_SQ_X: begin
        prod <= sq;
      end
      UOP_SQ_Y: begin
        prod <= sq;
        acc  <= ACC_W'(prod);
      end
      UOP_SQ_Z: begin
        prod <= sq;
        acc  <= acc + ACC_W'(prod);
      end
      UOP_SUM: begin
        acc <= acc + ACC_W'(prod);
      end
      UOP_SQRT_INIT: begin
        rem    <= acc;
        root   <= '0;
        sq_bit <= ACC_W'(1) << (2 * (ROOT_W - 1));
      end
      UOP_SQRT_STEP: begin
        if (trial_ge) begin
          rem  <= rem - trial;
          root <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      UOP_EMIT_STEP: begin
        if (emit_ok) begin
          last_x       <= cur_x;
          last_y       <= cur_y;
          last_z       <= cur_z;
          out_first    <= 1'b0;
          out_fb       <= goal_active;
          out_traveled <= total_sat;
          out_reached  <= reached;
        end
      end
      UOP_EMIT_FIRST: begin
        if (emit_ok) begin
          last_x       <= cur_x;
          last_y       <= cur_y;
          last_z       <= cur_z;
          out_first    <= 1'b1;
          out_fb       <= 1'b0;
          out_traveled <= path_total;
          out_reached  <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.valid          = out_valid;
  assign result.first_sample   = out_first;
  assign result.feedback_valid = out_fb;
  assign result.traveled       = out_traveled;
  assign result.goal_reached   = out_reached;

endmodule

// ===== hdl/odometry_path_distance_goal_core.sv =====
// A first sample goes from acceptance straight to the first-sample emit step; any later sample
//   passes through the square, sum and square-root steps before its emit step.
// A new sample is taken only after the previous one has been emitted; the digit-serial square
//   root, one root bit per cycle, is the longest of these steps.
// A result waits in the output register; the next sample is taken meanwhile.
// Synchronous reset: goal_distance all ones, goal_active 0, path total and history cleared.
module odometry_path_distance_goal_core #(
  parameter int unsigned POS_BITS = opdg_pkg::POS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [opdg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opdg_pkg::CFG_DATA_W-1:0] cfg_data,
  opdg_in_if.sink                         sample,
  opdg_out_if.source                      result
);
  import opdg_pkg::*;

  uop_t  uop;
  stat_t stat;

  // Control store and step counter
  opdg_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .uop  (uop)
  );

  // Position, root and path datapath
  opdg_dpath #(
    .POS_BITS (POS_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .uop       (uop),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .result    (result)
  );

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opdg_pkg::*;

  localparam int unsigned POS_BITS    = POS_BITS_DEF;
  localparam int          ITEM_TARGET = 1850;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          LONG_HOLD   = 400;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef enum int {MOVE_SMALL, MOVE_WIDE, MOVE_EXTREME, MOVE_MIXED} move_t;

  typedef struct packed {
    logic        first_sample;
    logic        feedback_valid;
    logic [31:0] traveled;
    logic        goal_reached;
  } path_report_t;

  // Tracks path length and goal state, queues the report each sample should produce
  class path_tracker;
    bit [31:0]                   goal_dist;
    bit                          goal_on;
    logic signed [POS_BITS-1:0]  prev_x, prev_y, prev_z;
    bit                          have_pos;
    bit [31:0]                   total;
    path_report_t                pending_reports[$];
    int                          errors;

    function new();
      goal_dist = 32'hFFFF_FFFF;
      goal_on   = 1'b0;
      prev_x    = '0;
      prev_y    = '0;
      prev_z    = '0;
      have_pos  = 1'b0;
      total     = '0;
      errors    = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GOAL_DISTANCE: goal_dist = data[31:0];
        REG_GOAL_ACTIVE:   goal_on   = data[0];
        default: ;
      endcase
    endfunction

    // Floor square root, one result bit at a time from the top
    function bit [31:0] floor_root(longint unsigned n);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root[31:0];
    endfunction

    function void note_sample(logic signed [POS_BITS-1:0] x, y, z);
      path_report_t    rep;
      longint          dx, dy, dz;
      longint unsigned dist_sq, grown;
      if (!have_pos) begin
        // first sample only loads the stored position
        rep.first_sample   = 1'b1;
        rep.feedback_valid = 1'b0;
        rep.traveled       = total;
        rep.goal_reached   = 1'b0;
        have_pos = 1'b1;
      end else begin
        dx = longint'(x) - longint'(prev_x);
        dy = longint'(y) - longint'(prev_y);
        dz = longint'(z) - longint'(prev_z);
        dist_sq = dx * dx + dy * dy + dz * dz;
        grown = longint'(total) + longint'(floor_root(dist_sq));
        if (grown > 64'hFFFF_FFFF) grown = 64'hFFFF_FFFF;
        total = grown[31:0];
        rep.first_sample   = 1'b0;
        rep.feedback_valid = goal_on;
        rep.traveled       = total;
        rep.goal_reached   = (total >= goal_dist);
        if (rep.goal_reached) total = '0;
      end
      prev_x = x;
      prev_y = y;
      prev_z = z;
      pending_reports = {pending_reports, rep};
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(path_report_t seen);
      path_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: result beat with nothing expected: traveled %0d", $time,
                 seen.traveled);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      field_check("first_sample", 32'(want.first_sample), 32'(seen.first_sample));
      field_check("feedback_valid", 32'(want.feedback_valid), 32'(seen.feedback_valid));
      field_check("traveled", want.traveled, seen.traveled);
      field_check("goal_reached", 32'(want.goal_reached), 32'(seen.goal_reached));
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  opdg_in_if #(.POS_BITS(POS_BITS)) sample_bus();
  opdg_out_if                       result_bus();

  odometry_path_distance_goal_core #(.POS_BITS(POS_BITS)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_bus),
    .result    (result_bus)
  );

  path_tracker tracker = new();

  bit src_idle_on;
  bit snk_idle_on;
  bit hold_req;
  int sent_count;
  int cycles;
  logic signed [POS_BITS-1:0] cur_x, cur_y, cur_z;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [POS_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [31:0] pick_goal();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom_range(50, 3000);
      3: return $urandom_range(1_000_000, 200_000_000);
      4: return $urandom();
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.apply_reg(idx, data);
  endtask

  // One sample beat; valid stays high when the next beat follows at once
  task automatic send_pos(input logic signed [POS_BITS-1:0] x, y, z);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.pos_x <= x;
    sample_bus.pos_y <= y;
    sample_bus.pos_z <= z;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    tracker.note_sample(x, y, z);
    cur_x = x;
    cur_y = y;
    cur_z = z;
    sent_count++;
  endtask

  task automatic random_move(input move_t style);
    move_t m;
    logic signed [POS_BITS-1:0] nx, ny, nz;
    m = (style == MOVE_MIXED) ? move_t'($urandom_range(0, 2)) : style;
    case (m)
      MOVE_SMALL: begin
        // short steps, occasionally standing still
        if ($urandom_range(0, 9) == 0) begin
          nx = cur_x;
          ny = cur_y;
          nz = cur_z;
        end else begin
          nx = cur_x + POS_BITS'($urandom_range(0, 64)) - POS_BITS'(32);
          ny = cur_y + POS_BITS'($urandom_range(0, 64)) - POS_BITS'(32);
          nz = cur_z + POS_BITS'($urandom_range(0, 64)) - POS_BITS'(32);
        end
      end
      MOVE_WIDE: begin
        nx = POS_BITS'($urandom());
        ny = POS_BITS'($urandom());
        nz = POS_BITS'($urandom());
      end
      default: begin
        nx = pick_extreme();
        ny = pick_extreme();
        nz = pick_extreme();
      end
    endcase
    send_pos(nx, ny, nz);
  endtask

  // Drop valid and let every queued report come back
  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Result side: check each beat, random stalls plus one long hold-off
  initial begin
    int           stall_left;
    int           hold_left;
    bit           hold_done;
    path_report_t seen;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid && result_bus.ready) begin
        seen.first_sample   = result_bus.first_sample;
        seen.feedback_valid = result_bus.feedback_valid;
        seen.traveled       = result_bus.traveled;
        seen.goal_reached   = result_bus.goal_reached;
        tracker.check_result(seen);
      end
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && snk_idle_on) stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("odometry_path_distance_goal_core test failed");
    $finish;
  end

  // Stimulus
  initial begin
    int    phase;
    int    n;
    move_t style;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    sample_bus.valid <= 1'b0;
    sample_bus.pos_x <= '0;
    sample_bus.pos_y <= '0;
    sample_bus.pos_z <= '0;
    hold_req         <= 1'b0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    sent_count  = 0;
    cur_x = '0;
    cur_y = '0;
    cur_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset config: no goal, feedback off; first sample only loads position
    send_pos(POS_MAX, POS_MIN, '0);
    send_pos(POS_MAX, POS_MIN, '0);
    send_pos(POS_MIN, POS_MAX, '1);
    send_pos(POS_MAX, POS_MAX, POS_MAX);
    send_pos(POS_MIN, POS_MIN, POS_MIN);
    send_pos('0, '0, '0);
    send_pos(POS_BITS'(3), POS_BITS'(4), POS_BITS'(0));
    send_pos(POS_BITS'(5), POS_BITS'(7), POS_BITS'(6));

    // Zero goal: every sample reaches it; high data bits ignored on goal_active
    wait_drained();
    write_reg(REG_GOAL_DISTANCE, 32'd0);
    write_reg(REG_GOAL_ACTIVE, 32'hFFFF_FFFF);
    send_pos(POS_BITS'(1), POS_BITS'(0), POS_BITS'(0));
    send_pos(POS_BITS'(1), POS_BITS'(0), POS_BITS'(0));
    send_pos('1, '1, '1);
    send_pos(POS_MIN, '0, POS_MAX);

    // Small goal reached exactly, feedback off again
    wait_drained();
    write_reg(REG_GOAL_DISTANCE, 32'd40);
    write_reg(REG_GOAL_ACTIVE, 32'hFFFF_FFFE);
    send_pos('0, '0, '0);
    send_pos(POS_BITS'(9), POS_BITS'(12), POS_BITS'(0));
    send_pos(POS_BITS'(9), POS_BITS'(12), POS_BITS'(20));
    send_pos(POS_BITS'(9), POS_BITS'(12), POS_BITS'(25));
    send_pos(POS_BITS'(9), POS_BITS'(12), POS_BITS'(26));

    // Largest steps until the total saturates and clears on the all-ones goal
    wait_drained();
    write_reg(REG_GOAL_DISTANCE, 32'hFFFF_FFFF);
    write_reg(REG_GOAL_ACTIVE, 32'd1);
    for (int i = 0; i < 160; i++) begin
      if (i % 2 == 0) send_pos(POS_MAX, POS_MAX, POS_MAX);
      else send_pos(POS_MIN, POS_MIN, POS_MIN);
    end

    // Random phases, each with its own goal and idling mix
    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      phase++;
      wait_drained();
      write_reg(REG_GOAL_DISTANCE, pick_goal());
      write_reg(REG_GOAL_ACTIVE, $urandom());
      style = move_t'($urandom_range(0, 3));
      n = $urandom_range(100, 180);
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end
      if (phase == 4) begin
        // sender keeps offering while the result side holds off
        src_idle_on = 1'b0;
        hold_req <= 1'b1;
      end
      repeat (n) random_move(style);
    end

    sample_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("odometry_path_distance_goal_core test passed");
    end else begin
      $display("odometry_path_distance_goal_core test failed");
    end
    $finish;
  end

endmodule
